@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the vector stroke text generator.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define VSTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds in the cycle after its trigger, outside reset.
`define VSTG_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/vstg_pkg.sv @@
// Package for the vector stroke text generator: glyph tables, stroke ROM,
// control word type and sequencer step codes. Depends on nothing.
`default_nettype none
package vstg_pkg;

  localparam int unsigned RomDepth = 174;
  localparam int unsigned NumGlyph = 36;

  typedef logic [7:0] rom_addr_t;
  typedef logic [3:0] glen_t;

  // One stroke point: offset in the 5 x 7 cell and the pen-down mark.
  typedef struct packed {
    logic [2:0] px;
    logic [2:0] py;
    logic       down;
  } stroke_t;

  // Sequencer steps.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_SPARE = 2'd3;

  // Jump conditions.
  localparam logic [1:0] C_NONE  = 2'd0;
  localparam logic [1:0] C_GLYPH = 2'd1;
  localparam logic [1:0] C_END   = 2'd2;

  typedef struct packed {
    logic       take_in;
    logic       load_glyph;
    logic       walk;
    logic [1:0] cond;
    logic [1:0] jmp;
    logic [1:0] seq;
  } ctrl_t;

  localparam ctrl_t UCODE [4] = '{
    '{take_in: 1'b1, load_glyph: 1'b0, walk: 1'b0, cond: C_GLYPH, jmp: S_LOAD, seq: S_IDLE},
    '{take_in: 1'b0, load_glyph: 1'b1, walk: 1'b0, cond: C_NONE,  jmp: S_IDLE, seq: S_WALK},
    '{take_in: 1'b0, load_glyph: 1'b0, walk: 1'b1, cond: C_END,   jmp: S_IDLE, seq: S_WALK},
    '{take_in: 1'b0, load_glyph: 1'b0, walk: 1'b0, cond: C_NONE,  jmp: S_IDLE, seq: S_IDLE}
  };

  function automatic stroke_t pt(input int unsigned x, input int unsigned y,
                                 input int unsigned d);
    pt = '{px: 3'(x), py: 3'(y), down: 1'(d)};
  endfunction

  localparam stroke_t STROKE_ROM [RomDepth] = '{
    // A
    pt(0,4,1),pt(2,6,1),pt(4,4,1),pt(4,0,1),pt(0,2,0),pt(4,2,1),
    // B
    pt(0,6,1),pt(3,6,1),pt(4,5,1),pt(4,4,1),pt(3,3,1),pt(0,3,1),pt(3,3,0),pt(4,2,1),
    pt(4,1,1),pt(3,0,1),pt(0,0,1),
    // C
    pt(0,6,1),pt(4,6,1),pt(0,0,0),pt(4,0,1),
    // D
    pt(0,6,1),pt(2,6,1),pt(4,4,1),pt(4,2,1),pt(2,0,1),pt(0,0,1),
    // E
    pt(0,6,1),pt(4,6,1),pt(3,3,0),pt(0,3,1),pt(0,0,0),pt(4,0,1),
    // F
    pt(0,6,1),pt(4,6,1),pt(3,3,0),pt(0,3,1),pt(0,0,0),
    // G
    pt(0,6,1),pt(4,6,1),pt(4,4,1),pt(2,2,0),pt(4,2,1),pt(4,0,1),pt(0,0,1),
    // H
    pt(0,6,1),pt(0,3,0),pt(4,3,1),pt(4,6,0),pt(4,0,1),
    // I
    pt(4,0,1),pt(2,0,0),pt(2,6,1),pt(4,6,0),pt(0,6,1),
    // J
    pt(0,2,0),pt(2,0,1),pt(4,0,1),pt(4,6,1),
    // K
    pt(0,6,1),pt(3,6,0),pt(0,3,1),pt(3,0,1),
    // L
    pt(0,6,0),pt(0,0,1),pt(4,0,1),
    // M
    pt(0,6,1),pt(2,4,1),pt(4,6,1),pt(4,0,1),
    // N
    pt(0,6,1),pt(4,0,1),pt(4,6,1),
    // O
    pt(0,6,1),pt(4,6,1),pt(4,0,1),pt(0,0,1),
    // P
    pt(0,6,1),pt(4,6,1),pt(4,3,1),pt(0,3,1),pt(3,0,0),
    // Q
    pt(0,6,1),pt(4,6,1),pt(4,2,1),pt(2,0,1),pt(0,0,1),pt(2,2,0),pt(4,0,1),
    // R
    pt(0,6,1),pt(4,6,1),pt(4,3,1),pt(0,3,1),pt(1,3,0),pt(4,0,1),
    // S
    pt(4,0,1),pt(4,3,1),pt(0,3,1),pt(0,6,1),pt(4,6,1),
    // T
    pt(2,0,0),pt(2,6,1),pt(0,6,0),pt(4,6,1),
    // U
    pt(0,6,0),pt(0,0,1),pt(4,0,1),pt(4,6,1),
    // V
    pt(0,6,0),pt(2,0,1),pt(4,6,1),
    // W
    pt(0,6,0),pt(0,0,1),pt(2,2,1),pt(4,0,1),pt(4,6,1),
    // X
    pt(4,6,1),pt(0,6,0),pt(4,0,1),
    // Y
    pt(2,0,0),pt(2,4,1),pt(0,6,1),pt(4,6,0),pt(2,4,1),
    // Z
    pt(0,6,0),pt(4,6,1),pt(0,0,1),pt(4,0,1),
    // 0
    pt(0,6,1),pt(4,6,1),pt(4,0,1),pt(0,0,1),
    // 1
    pt(2,0,0),pt(2,6,1),
    // 2
    pt(0,6,0),pt(4,6,1),pt(4,3,1),pt(0,3,1),pt(0,0,1),pt(4,0,1),
    // 3
    pt(4,0,1),pt(4,6,1),pt(0,6,1),pt(0,3,0),pt(4,3,1),
    // 4
    pt(0,6,0),pt(0,3,1),pt(4,3,1),pt(4,6,0),pt(4,0,1),
    // 5
    pt(4,0,1),pt(4,3,1),pt(0,3,1),pt(0,6,1),pt(4,6,1),
    // 6
    pt(0,3,0),pt(4,3,1),pt(4,0,1),pt(0,0,1),pt(0,6,1),
    // 7
    pt(0,6,0),pt(4,6,1),pt(4,0,1),
    // 8
    pt(4,0,1),pt(4,6,1),pt(0,6,1),pt(0,0,1),pt(0,3,0),pt(4,3,1),
    // 9
    pt(4,0,0),pt(4,6,1),pt(0,6,1),pt(0,3,1),pt(4,3,1)
  };

  // Glyph slots: 'A'..'Z' then '0'..'9'.
  localparam rom_addr_t GLYPH_FIRST [NumGlyph] = '{
    8'd0,8'd6,8'd17,8'd21,8'd27,8'd33,8'd38,8'd45,8'd50,8'd55,8'd59,8'd63,8'd66,
    8'd70,8'd73,8'd77,8'd82,8'd89,8'd95,8'd100,8'd104,8'd108,8'd111,8'd116,8'd119,
    8'd124,8'd128,8'd132,8'd134,8'd140,8'd145,8'd150,8'd155,8'd160,8'd163,8'd169
  };
  localparam glen_t GLYPH_LEN [NumGlyph] = '{
    4'd6,4'd11,4'd4,4'd6,4'd6,4'd5,4'd7,4'd5,4'd5,4'd4,4'd4,4'd3,4'd4,4'd3,4'd4,
    4'd5,4'd7,4'd6,4'd5,4'd4,4'd4,4'd3,4'd5,4'd3,4'd5,4'd4,
    4'd4,4'd2,4'd6,4'd5,4'd5,4'd5,4'd5,4'd3,4'd6,4'd5
  };
  // Point index of the last pen-down point; F and P end on a pen-up move.
  localparam glen_t GLYPH_LASTDN [NumGlyph] = '{
    4'd5,4'd10,4'd3,4'd5,4'd5,4'd3,4'd6,4'd4,4'd4,4'd3,4'd3,4'd2,4'd3,4'd2,4'd3,
    4'd3,4'd6,4'd5,4'd4,4'd3,4'd3,4'd2,4'd4,4'd2,4'd4,4'd3,
    4'd3,4'd1,4'd5,4'd4,4'd4,4'd4,4'd4,4'd2,4'd5,4'd4
  };

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic signed [15:0] PEN_HOME_Y = -16'sd7;
  localparam logic [15:0] ADVANCE_X = 16'd6;
  localparam logic [15:0] LINE_DROP = 16'd10;

endpackage
`default_nettype wire

@@ rtl/vector_stroke_text_generator.sv @@
// Vector stroke text generator: top level with microcoded sequencer and datapath.
// Depends on vstg_pkg and assert_macros.svh.
//
// Usage. Characters enter on the in_ stream, one word each: in_tdata holds the
// character byte and in_tuser the new-message flag, which homes the pen to
// (0,-7) before the character is handled. Each drawn character produces one
// to ten line segment words on the out_ stream; out_tlast marks the final
// segment of a character. Newline, space and unsupported codes produce no
// output; they only move the pen (or leave it).
// A drawn character passes an accept step, a glyph lookup step and a walk
// over its stroke points in the glyph ROM, one point per cycle while no
// pen-down point is stalled. The first segment is written to the output
// register in the first walk step, after the lookup step, when the first
// stroke point of the glyph is pen-down.
// A new character is accepted only once the previous glyph walk has ended,
// while its last segment may still wait in the output register.
// When the receiver stalls, the walk holds on the next pen-down point until
// the output register frees; pen-up points proceed.
// Reset (synchronous, rst_n low) sets the pen to (0,-7), empties the output
// register and returns the sequencer to its idle step.
`default_nettype none
`include "assert_macros.svh"
module vector_stroke_text_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tuser,   // [0] new_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // x_start, y_start, x_end, y_end from bit 0 up (16 each)
  output logic             out_tlast   // last_in_glyph
);

  logic [1:0] step_r, step_nxt;
  vstg_pkg::ctrl_t cw;

  logic signed [15:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic signed [15:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [5:0] slot_r, slot_nxt;
  vstg_pkg::rom_addr_t first_r, first_nxt;
  vstg_pkg::glen_t len_r, len_nxt, lastdn_r, lastdn_nxt, cnt_r, cnt_nxt;

  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic accept, is_glyph, stall, advance, walk_end;
  logic [5:0] dec_slot;
  vstg_pkg::stroke_t p;
  logic signed [15:0] hx, hy, nx, ny;

  // Saturating add of a small signed delta to a 16-bit coordinate.
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [16:0] d);
    logic signed [16:0] s;
    s = 17'(a) + d;
    if (s > 17'sd32767) sat_add = 16'sh7fff;
    else if (s < -17'sd32768) sat_add = 16'sh8000;
    else sat_add = s[15:0];
  endfunction

  assign cw = vstg_pkg::UCODE[step_r];
  assign in_tready = cw.take_in;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    is_glyph = 1'b0;
    dec_slot = '0;
    if (in_tdata >= 8'h41 && in_tdata <= 8'h5a) begin
      is_glyph = 1'b1;
      dec_slot = 6'(in_tdata - 8'h41);
    end else if (in_tdata >= 8'h30 && in_tdata <= 8'h39) begin
      is_glyph = 1'b1;
      dec_slot = 6'(in_tdata - 8'h30 + 8'd26);
    end
  end

  assign p = vstg_pkg::STROKE_ROM[first_r + 8'(cnt_r)];
  assign nx = sat_add(pen_x_r, 17'(p.px));
  assign ny = sat_add(pen_y_r, 17'(p.py));
  assign stall = p.down && out_valid_r && !out_tready;
  assign advance = cw.walk && !stall;
  assign walk_end = advance && (cnt_r == len_r - 4'd1);

  always_comb begin
    step_nxt = cw.seq;
    unique case (cw.cond)
      vstg_pkg::C_GLYPH: if (accept && is_glyph) step_nxt = cw.jmp;
      vstg_pkg::C_END:   if (walk_end) step_nxt = cw.jmp;
      default:           step_nxt = cw.seq;
    endcase
  end

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    slot_nxt = slot_r;
    first_nxt = first_r;
    len_nxt = len_r;
    lastdn_nxt = lastdn_r;
    cnt_nxt = cnt_r;
    bx_nxt = bx_r;
    by_nxt = by_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r;
    out_data_nxt = out_data_r;

    if (accept) begin
      hx = in_tuser ? 16'sd0 : pen_x_r;
      hy = in_tuser ? vstg_pkg::PEN_HOME_Y : pen_y_r;
      pen_x_nxt = hx;
      pen_y_nxt = hy;
      slot_nxt = dec_slot;
      if (in_tdata == vstg_pkg::CHAR_NL) begin
        pen_x_nxt = 16'sd0;
        pen_y_nxt = sat_add(hy, -17'(vstg_pkg::LINE_DROP));
      end else if (in_tdata == vstg_pkg::CHAR_SPACE) begin
        pen_x_nxt = sat_add(hx, 17'(vstg_pkg::ADVANCE_X));
      end
    end else begin
      hx = pen_x_r;
      hy = pen_y_r;
    end

    if (cw.load_glyph) begin
      first_nxt = vstg_pkg::GLYPH_FIRST[slot_r];
      len_nxt = vstg_pkg::GLYPH_LEN[slot_r];
      lastdn_nxt = vstg_pkg::GLYPH_LASTDN[slot_r];
      cnt_nxt = '0;
      bx_nxt = pen_x_r;
      by_nxt = pen_y_r;
    end

    if (advance) begin
      if (p.down) begin
        out_valid_nxt = 1'b1;
        out_last_nxt = (cnt_r == lastdn_r);
        out_data_nxt = {ny, nx, by_r, bx_r};
      end
      bx_nxt = nx;
      by_nxt = ny;
      cnt_nxt = cnt_r + 4'd1;
      if (walk_end) pen_x_nxt = sat_add(pen_x_r, 17'(vstg_pkg::ADVANCE_X));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= vstg_pkg::S_IDLE;
      pen_x_r <= 16'sd0;
      pen_y_r <= vstg_pkg::PEN_HOME_Y;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      step_r <= step_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    first_r <= first_nxt;
    len_r <= len_nxt;
    lastdn_r <= lastdn_nxt;
    bx_r <= bx_nxt;
    by_r <= by_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  `VSTG_ASSERT_NEXT(a_glyph_loads, accept && is_glyph, step_r == vstg_pkg::S_LOAD, "glyph not loaded")
  `VSTG_ASSERT(a_walk_in_range, (step_r == vstg_pkg::S_WALK) |-> (cnt_r < len_r), "walk index past glyph")
  `VSTG_ASSERT_NEXT(a_stall_holds, cw.walk && stall, $stable(cnt_r) && out_tvalid, "walk moved while stalled")
  `VSTG_ASSERT(a_no_spare_step, step_r != vstg_pkg::S_SPARE, "sequencer in spare step")

endmodule
`default_nettype wire
